// ----- design/sit_pkg.sv -----
// Shared types and constants for the segment intersection test block.
`default_nettype none
package sit_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ----- design/sit_front.sv -----
// Front stage: accepts a segment pair and forms the coordinate differences.
`default_nettype none
module sit_front #(
  parameter int W = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [W-1:0]         a_start_x,
  input  wire logic [W-1:0]         a_start_y,
  input  wire logic [W-1:0]         a_end_x,
  input  wire logic [W-1:0]         a_end_y,
  input  wire logic [W-1:0]         b_start_x,
  input  wire logic [W-1:0]         b_start_y,
  input  wire logic [W-1:0]         b_end_x,
  input  wire logic [W-1:0]         b_end_y,
  input  wire sit_pkg::q_stat_t     q_stat,
  output logic                      push,
  output logic [2*W+6*(W+1)-1:0]    push_word
);

  localparam int D = W + 1;

  logic         front_v_r;
  logic         front_adv;
  logic [D-1:0] dax_r, day_r, dbx_r, dby_r, wx_r, wy_r;
  logic [W-1:0] x1_r, y1_r;

  function automatic logic [D-1:0] sub_ext(input logic [W-1:0] a, input logic [W-1:0] b);
    sub_ext = {a[W-1], a} - {b[W-1], b};
  endfunction

  assign front_adv = !front_v_r || !q_stat.full;
  assign in_stall  = !front_adv;
  assign push      = front_v_r && !q_stat.full;
  assign push_word = {x1_r, y1_r, dax_r, day_r, dbx_r, dby_r, wx_r, wy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else if (front_adv) begin
      front_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_adv && in_valid) begin
      x1_r  <= a_start_x;
      y1_r  <= a_start_y;
      dax_r <= sub_ext(a_end_x, a_start_x);
      day_r <= sub_ext(a_end_y, a_start_y);
      dbx_r <= sub_ext(b_end_x, b_start_x);
      dby_r <= sub_ext(b_end_y, b_start_y);
      wx_r  <= sub_ext(a_start_x, b_start_x);
      wy_r  <= sub_ext(a_start_y, b_start_y);
    end
  end

endmodule
`default_nettype wire

// ----- design/sit_queue.sv -----
// Short word queue between the front stage and the arithmetic pipeline.
`default_nettype none
module sit_queue #(
  parameter int DW = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [DW-1:0]    push_word,
  input  wire logic             pop,
  output logic [DW-1:0]         head_word,
  output sit_pkg::q_stat_t      q_stat
);

  logic [DW-1:0]                 mem_r [sit_pkg::QDEPTH];
  logic [sit_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [sit_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == sit_pkg::QCNT_W'(sit_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head_word    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule
`default_nettype wire

// ----- design/sit_back.sv -----
// Arithmetic pipeline: Cramer products, range test, scaling and division.
`default_nettype none
module sit_back #(
  parameter int W = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire sit_pkg::q_stat_t          q_stat,
  input  wire logic [2*W+6*(W+1)-1:0]    head_word,
  output logic                           pop,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_hit,
  output logic [W-1:0]                   out_cross_x,
  output logic [W-1:0]                   out_cross_y
);

  localparam int D    = W + 1;
  localparam int DETW = 2 * D + 1;
  localparam int REMW = 3 * D + 1;

  logic adv;
  assign adv = !out_valid || !out_stall;
  assign pop = adv && !q_stat.empty;

  // Stage 1: six products.
  logic                   v1_r;
  logic signed [D-1:0]    dax, day, dbx, dby, wx, wy;
  logic [W-1:0]           hx1, hy1;
  logic signed [2*D-1:0]  p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  logic [W-1:0]           x1_1_r, y1_1_r;
  logic signed [D-1:0]    dax_1_r, day_1_r;

  assign {hx1, hy1, dax, day, dbx, dby, wx, wy} = head_word;

  // Stage 2: determinant and numerators.
  logic                   v2_r;
  logic signed [DETW-1:0] det_2_r, ns_2_r, nt_2_r;
  logic [W-1:0]           x1_2_r, y1_2_r;
  logic signed [D-1:0]    dax_2_r, day_2_r;

  // Stage 3: sign adjust and range test.
  logic                   v3_r;
  logic signed [DETW-1:0] det_a, ns_a, nt_a;
  logic                   hit_c;
  logic                   hit_3_r;
  logic [DETW-1:0]        det_3_r, nt_3_r;
  logic [W-1:0]           x1_3_r, y1_3_r, adx_3_r, ady_3_r;
  logic                   sx_3_r, sy_3_r;
  logic signed [D-1:0]    ndax, nday;

  // Stage 4: split products of nt with the direction of segment a.
  logic                   v4_r;
  logic [D+W-1:0]         lox_4_r, loy_4_r;
  logic [D+W:0]           hix_4_r, hiy_4_r;
  logic                   hit_4_r, sx_4_r, sy_4_r;
  logic [DETW-1:0]        det_4_r;
  logic [W-1:0]           x1_4_r, y1_4_r;

  // Divider stages, index 0 is the loaded dividend.
  logic                   vd_r   [W+1];
  logic [REMW-1:0]        remx_r [W+1];
  logic [REMW-1:0]        remy_r [W+1];
  logic [W-1:0]           qx_r   [W+1];
  logic [W-1:0]           qy_r   [W+1];
  logic [DETW-1:0]        detd_r [W+1];
  logic                   hitd_r [W+1];
  logic                   sxd_r  [W+1];
  logic                   syd_r  [W+1];
  logic [W-1:0]           x1d_r  [W+1];
  logic [W-1:0]           y1d_r  [W+1];

  always_comb begin
    det_a = det_2_r;
    ns_a  = ns_2_r;
    nt_a  = nt_2_r;
    if (det_2_r < 0) begin
      det_a = -det_2_r;
      ns_a  = -ns_2_r;
      nt_a  = -nt_2_r;
    end
    hit_c = (det_a != '0) && (ns_a >= 0) && (nt_a >= 0) && (ns_a <= det_a) && (nt_a <= det_a);
    ndax  = -dax_2_r;
    nday  = -day_2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= !q_stat.empty;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r    <= dax * dby;
      p2_r    <= dbx * day;
      p3_r    <= dax * wy;
      p4_r    <= day * wx;
      p5_r    <= dbx * wy;
      p6_r    <= dby * wx;
      x1_1_r  <= hx1;
      y1_1_r  <= hy1;
      dax_1_r <= dax;
      day_1_r <= day;

      det_2_r <= {p1_r[2*D-1], p1_r} - {p2_r[2*D-1], p2_r};
      ns_2_r  <= {p3_r[2*D-1], p3_r} - {p4_r[2*D-1], p4_r};
      nt_2_r  <= {p5_r[2*D-1], p5_r} - {p6_r[2*D-1], p6_r};
      x1_2_r  <= x1_1_r;
      y1_2_r  <= y1_1_r;
      dax_2_r <= dax_1_r;
      day_2_r <= day_1_r;

      hit_3_r <= hit_c;
      det_3_r <= det_a;
      nt_3_r  <= hit_c ? nt_a : '0;
      x1_3_r  <= x1_2_r;
      y1_3_r  <= y1_2_r;
      sx_3_r  <= dax_2_r[D-1];
      sy_3_r  <= day_2_r[D-1];
      adx_3_r <= dax_2_r[D-1] ? ndax[W-1:0] : dax_2_r[W-1:0];
      ady_3_r <= day_2_r[D-1] ? nday[W-1:0] : day_2_r[W-1:0];

      lox_4_r <= nt_3_r[D-1:0] * adx_3_r;
      loy_4_r <= nt_3_r[D-1:0] * ady_3_r;
      hix_4_r <= nt_3_r[DETW-1:D] * adx_3_r;
      hiy_4_r <= nt_3_r[DETW-1:D] * ady_3_r;
      hit_4_r <= hit_3_r;
      sx_4_r  <= sx_3_r;
      sy_4_r  <= sy_3_r;
      det_4_r <= det_3_r;
      x1_4_r  <= x1_3_r;
      y1_4_r  <= y1_3_r;
    end
  end

  // Stage 5: assemble the full dividends.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else if (adv) begin
      vd_r[0] <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      remx_r[0] <= {hix_4_r, {D{1'b0}}} + REMW'(lox_4_r);
      remy_r[0] <= {hiy_4_r, {D{1'b0}}} + REMW'(loy_4_r);
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      detd_r[0] <= det_4_r;
      hitd_r[0] <= hit_4_r;
      sxd_r[0]  <= sx_4_r;
      syd_r[0]  <= sy_4_r;
      x1d_r[0]  <= x1_4_r;
      y1d_r[0]  <= y1_4_r;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar j = 0; j < W; j++) begin : g_div
    localparam int B = W - 1 - j;
    logic [REMW-1:0] dsh;
    logic            gex, gey;

    assign dsh = REMW'(detd_r[j]) << B;
    assign gex = remx_r[j] >= dsh;
    assign gey = remy_r[j] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[j+1] <= 1'b0;
      end else if (adv) begin
        vd_r[j+1] <= vd_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        remx_r[j+1]    <= gex ? remx_r[j] - dsh : remx_r[j];
        remy_r[j+1]    <= gey ? remy_r[j] - dsh : remy_r[j];
        qx_r[j+1]      <= qx_r[j] | (W'(gex) << B);
        qy_r[j+1]      <= qy_r[j] | (W'(gey) << B);
        detd_r[j+1]    <= detd_r[j];
        hitd_r[j+1]    <= hitd_r[j];
        sxd_r[j+1]     <= sxd_r[j];
        syd_r[j+1]     <= syd_r[j];
        x1d_r[j+1]     <= x1d_r[j];
        y1d_r[j+1]     <= y1d_r[j];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vd_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit     <= hitd_r[W];
      out_cross_x <= !hitd_r[W] ? '0 :
                     (sxd_r[W] ? x1d_r[W] - qx_r[W] : x1d_r[W] + qx_r[W]);
      out_cross_y <= !hitd_r[W] ? '0 :
                     (syd_r[W] ? y1d_r[W] - qy_r[W] : y1d_r[W] + qy_r[W]);
    end
  end

endmodule
`default_nettype wire

// ----- design/segment_intersection_test.sv -----
// Top level of the segment intersection test block.
`default_nettype none
// Accepts one segment pair per cycle while in_stall is low and returns one word
// per pair, in order. The front stage register is loaded at acceptance; the word
// then passes through the queue, five arithmetic stages, COORD_WIDTH restoring
// divider stages (one quotient bit each) and the output register. A four-word
// queue decouples the front stage from the pipeline.
module segment_intersection_test #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [COORD_WIDTH-1:0]  in_a_start_x,
  input  wire logic [COORD_WIDTH-1:0]  in_a_start_y,
  input  wire logic [COORD_WIDTH-1:0]  in_a_end_x,
  input  wire logic [COORD_WIDTH-1:0]  in_a_end_y,
  input  wire logic [COORD_WIDTH-1:0]  in_b_start_x,
  input  wire logic [COORD_WIDTH-1:0]  in_b_start_y,
  input  wire logic [COORD_WIDTH-1:0]  in_b_end_x,
  input  wire logic [COORD_WIDTH-1:0]  in_b_end_y,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_hit,
  output logic [COORD_WIDTH-1:0]       out_cross_x,
  output logic [COORD_WIDTH-1:0]       out_cross_y
);

  localparam int QW = 2 * COORD_WIDTH + 6 * (COORD_WIDTH + 1);

  sit_pkg::q_stat_t q_stat;
  logic             q_push, q_pop;
  logic [QW-1:0]    q_push_word, q_head_word;

  sit_front #(.W(COORD_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .a_start_x (in_a_start_x),
    .a_start_y (in_a_start_y),
    .a_end_x   (in_a_end_x),
    .a_end_y   (in_a_end_y),
    .b_start_x (in_b_start_x),
    .b_start_y (in_b_start_y),
    .b_end_x   (in_b_end_x),
    .b_end_y   (in_b_end_y),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_word (q_push_word)
  );

  sit_queue #(.DW(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_push_word),
    .pop       (q_pop),
    .head_word (q_head_word),
    .q_stat    (q_stat)
  );

  sit_back #(.W(COORD_WIDTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .head_word   (q_head_word),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_hit     (out_hit),
    .out_cross_x (out_cross_x),
    .out_cross_y (out_cross_y)
  );

`ifndef ASSERT_OFF
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full) else $error("push into full queue");
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty) else $error("pop from empty queue");
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty)) else $error("queue both full and empty");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_cross_x == '0 && out_cross_y == '0))
    else $error("nonzero point on a miss");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for the segment intersection test block: directed, random and back-pressure tests.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;

  typedef struct {
    logic signed [CW-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
  } seg_pair_t;

  typedef struct {
    logic                 hit;
    logic signed [CW-1:0] x, y;
  } crossing_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CW-1:0] in_a_start_x = '0, in_a_start_y = '0, in_a_end_x = '0, in_a_end_y = '0;
  logic [CW-1:0] in_b_start_x = '0, in_b_start_y = '0, in_b_end_x = '0, in_b_end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic [CW-1:0] out_cross_x, out_cross_y;

  crossing_t expected_crossings[$];
  int mismatches = 0;
  int hold_cycles = 0;
  bit quiet = 1'b0;

  segment_intersection_test #(.COORD_WIDTH(CW)) i_dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic crossing_t predict_crossing(seg_pair_t p);
    logic signed [127:0] dax, day, dbx, dby, wx, wy, det, ns, nt, qx, qy;
    crossing_t r;
    r.hit = 1'b0;
    r.x = '0;
    r.y = '0;
    dax = 128'(longint'(p.ax2) - longint'(p.ax1));
    day = 128'(longint'(p.ay2) - longint'(p.ay1));
    dbx = 128'(longint'(p.bx2) - longint'(p.bx1));
    dby = 128'(longint'(p.by2) - longint'(p.by1));
    wx = 128'(longint'(p.ax1) - longint'(p.bx1));
    wy = 128'(longint'(p.ay1) - longint'(p.by1));
    det = dax * dby - dbx * day;
    if (det == 0) return r;
    ns = dax * wy - day * wx;
    nt = dbx * wy - dby * wx;
    if (det < 0) begin
      det = -det;
      ns = -ns;
      nt = -nt;
    end
    if (ns < 0 || nt < 0 || ns > det || nt > det) return r;
    qx = (nt * dax) / det;
    qy = (nt * day) / det;
    r.hit = 1'b1;
    r.x = p.ax1 + qx[CW-1:0];
    r.y = p.ay1 + qy[CW-1:0];
    return r;
  endfunction

  // Drives one word and holds it until the block takes it; leaves valid high.
  task automatic send_pair(seg_pair_t p);
    bit taken;
    while (!quiet && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_a_start_x <= p.ax1;
    in_a_start_y <= p.ay1;
    in_a_end_x <= p.ax2;
    in_a_end_y <= p.ay2;
    in_b_start_x <= p.bx1;
    in_b_start_y <= p.by1;
    in_b_end_x <= p.bx2;
    in_b_end_y <= p.by2;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    expected_crossings.insert(expected_crossings.size(), predict_crossing(p));
  endtask

  task automatic send_coords(int ax1, int ay1, int ax2, int ay2,
                             int bx1, int by1, int bx2, int by2);
    seg_pair_t p;
    p = '{ax1, ay1, ax2, ay2, bx1, by1, bx2, by2};
    send_pair(p);
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 26);
    end
  end

  initial begin
    bit take;
    crossing_t got, want;
    forever begin
      @(negedge clk);
      take = rst_n && out_valid && !out_stall;
      got.hit = out_hit;
      got.x = out_cross_x;
      got.y = out_cross_y;
      @(posedge clk);
      if (take) begin
        if (expected_crossings.size() == 0) begin
          $display("%t: unexpected word hit=%0b x=%0d y=%0d", $realtime, got.hit, got.x, got.y);
          mismatches++;
        end else begin
          want = expected_crossings.pop_front();
          if (got.hit !== want.hit) begin
            $display("%t: hit expected %0b actual %0b", $realtime, want.hit, got.hit);
            mismatches++;
          end
          if (got.x !== want.x) begin
            $display("%t: cross_x expected %0d actual %0d", $realtime, want.x, got.x);
            mismatches++;
          end
          if (got.y !== want.y) begin
            $display("%t: cross_y expected %0d actual %0d", $realtime, want.y, got.y);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic test_directed;
    int mn, mx;
    mn = 32'sh8000_0000;
    mx = 32'sh7fff_ffff;
    send_coords(0, 0, 0, 0, 0, 0, 0, 0);
    send_coords(0, 0, 256, 256, 0, 256, 256, 0);
    send_coords(0, 256, 256, 0, 0, 0, 256, 256);
    send_coords(0, 0, 256, 0, 256, 0, 512, 512);
    send_coords(0, 0, 256, 0, 0, 256, 256, 256);
    send_coords(0, 0, 512, 0, 256, 0, 768, 0);
    send_coords(0, 0, 512, 0, 256, 0, 256, 512);
    send_coords(0, 0, 512, 0, 513, -5, 513, 5);
    send_coords(0, 0, 512, 0, 256, 1, 256, 9);
    send_coords(0, 0, -3, -7, -2, 1, 0, -9);
    send_coords(5, 5, 5, 5, 0, 0, 10, 10);
    send_coords(mn, mn, mx, mx, mn, mx, mx, mn);
    send_coords(mx, mn, mn, mx, mn, mn, mx, mx);
    send_coords(mn, mn, mn, mn, mx, mx, mx, mx);
    send_coords(mn, 0, mx, 0, 0, mn, 0, mx);
    send_coords(mx, mx, mn, mn, mx, mn, mn, mx);
    send_coords(mn, mn, mx, mn, mn, mn, mn, mx);
    send_coords(-1, -1, 1, 1, -1, 1, 1, -1);
    send_coords(0, 0, 7, 3, 0, 3, 7, 0);
    send_coords(0, 0, -7, 3, 0, 3, -7, 0);
  endtask

  function automatic int rand_coord(int mode);
    case (mode)
      0: return int'($urandom);
      1: return int'($urandom_range(8192)) - 4096;
      default: return int'($urandom_range(1 << 21)) - (1 << 20);
    endcase
  endfunction

  task automatic test_random(int count);
    seg_pair_t p;
    int mode;
    longint cx, cy;
    int dx, dy;
    for (int n = 0; n < count; n++) begin
      quiet = (n >= count / 3 && n < count / 3 + 150);
      mode = $urandom_range(4);
      p.ax1 = rand_coord(mode);
      p.ay1 = rand_coord(mode);
      p.ax2 = rand_coord(mode);
      p.ay2 = rand_coord(mode);
      p.bx1 = rand_coord(mode);
      p.by1 = rand_coord(mode);
      p.bx2 = rand_coord(mode);
      p.by2 = rand_coord(mode);
      if (mode == 3) begin
        cx = (longint'(p.ax1) + p.ax2) / 2;
        cy = (longint'(p.ay1) + p.ay2) / 2;
        dx = rand_coord(2);
        dy = rand_coord(2);
        p.bx1 = CW'(cx - dx);
        p.by1 = CW'(cy - dy);
        p.bx2 = CW'(cx + dx);
        p.by2 = CW'(cy + dy);
      end else if (mode == 4 && $urandom_range(1)) begin
        p.bx1 = p.ax2;
        p.by1 = p.ay2;
      end
      send_pair(p);
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure;
    hold_cycles = 300;
    quiet = 1'b1;
    for (int n = 0; n < 120; n++) begin
      send_coords(0, 0, 256 * (n + 1), 256, 0, 256, 256, 0);
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(900);
    test_backpressure();
    test_random(910);
    in_valid <= 1'b0;
    fork
      wait (expected_crossings.size() == 0);
      repeat (20000) @(posedge clk);
    join_any
    disable fork;
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_crossings.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
design/sit_pkg.sv
design/sit_front.sv
design/sit_queue.sv
design/sit_back.sv
design/segment_intersection_test.sv
sim/tb_top.sv
